// ----- hdl/line_follow_pd_steering_macros.svh -----
// Assertion macros for the line follower steering checker.
`ifndef LINE_FOLLOW_PD_STEERING_MACROS_SVH
`define LINE_FOLLOW_PD_STEERING_MACROS_SVH

// Same-cycle implication, off during reset.
`define LFPS_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LFPS_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define LFPS_ASSERT_NXT_ANY(label, a, c, msg) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error(msg);

`endif

// ----- hdl/lfps_pkg.sv -----
// Shared types and constants of the line follower steering block.
package lfps_pkg;

  localparam int KIND_BITS      = 2;
  localparam int GAIN_BITS      = 8;
  localparam int DUTY_BITS      = 8;
  localparam int SIDE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;
  localparam int OUT_BITS       = 24;
  localparam int OUT_USED_BITS  = 2 * DUTY_BITS + SIDE_BITS + 1;
  localparam int OUT_PAD_BITS   = OUT_BITS - OUT_USED_BITS;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CAL_LOW  = 2'd0,
    KIND_CAL_HIGH = 2'd1,
    KIND_RUN      = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_t;

  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_THRESH = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_P_NUM = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_D_NUM = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_DEN = 3'd4;

  localparam logic [SIDE_BITS-1:0] SIDE_NONE = 2'd0;
  localparam logic [SIDE_BITS-1:0] SIDE_POS  = 2'd1;
  localparam logic [SIDE_BITS-1:0] SIDE_NEG  = 2'd2;

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = 8'd255;

  localparam logic [CFG_DATA_BITS-1:0] BASE_SPEED_RESET  = 8'd240;
  localparam logic [CFG_DATA_BITS-1:0] STOP_THRESH_RESET = 8'd45;
  localparam logic [CFG_DATA_BITS-1:0] P_NUM_RESET       = 8'd10;
  localparam logic [CFG_DATA_BITS-1:0] D_NUM_RESET       = 8'd6;
  localparam logic [CFG_DATA_BITS-1:0] GAIN_DEN_RESET    = 8'd15;

endpackage

// ----- hdl/line_follow_pd_steering.sv -----
// Top level of the line follower PD steering controller.
//
// Input beats (s_*) carry three sensor samples in s_tdata and the kind in
// s_tuser. Calibrate-low and calibrate-high beats update the per-sensor
// minima and maxima and give no output; they are taken one per cycle while
// the block is idle. A run beat gives one output beat (m_*) with both
// motor duties, the side indicator and the stop flag. Its weighted sum is
// formed in the bit-serial multiplier (one weight bit per cycle) and
// divided in the restoring divider (one quotient bit per cycle); the block
// is ready for the next beat in the same cycle that the result appears on
// m_tvalid. Once halted, or on the beat that loses the line, the answer
// skips the arithmetic and goes straight from idle to the output state.
// The output register holds a result while m_tready is low; the block keeps
// taking input until it accepts a run beat, whose result then waits in the
// output state until that register is free.
// Reset clears the calibration and the halt latch, sets the configuration
// registers to their defaults and clears the output valid flag.
// Configuration writes (cfg_we) land at once, with no read-back.
module line_follow_pd_steering #(
  parameter int SAMPLE_BITS = 8,
  localparam int S_DATA_BITS = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_left, sample_mid, sample_right
  input  logic [S_DATA_BITS-1:0]               s_tdata,
  // kind
  input  logic [lfps_pkg::KIND_BITS-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // left_duty, right_duty, side_indicator, stopped
  output logic [lfps_pkg::OUT_BITS-1:0]        m_tdata,
  input  logic                                 cfg_we,
  input  logic [lfps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lfps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import lfps_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int EW = SB + 2;
  localparam int RW = SB + 3;
  localparam int AW = SB + 12;

  state_t state;
  state_t state_next;

  logic [7:0] base_speed;
  logic [7:0] stop_thresh;
  logic [7:0] p_num;
  logic [7:0] d_num;
  logic [7:0] gain_den;

  logic [SB-1:0] s_left;
  logic [SB-1:0] s_mid;
  logic [SB-1:0] s_right;
  logic [SB-1:0] low_left;
  logic [SB-1:0] low_mid;
  logic [SB-1:0] low_right;
  logic [SB-1:0] high_left;
  logic [SB-1:0] high_mid;
  logic [SB-1:0] high_right;

  kind_t kind;
  logic  accept;
  logic  run_beat;
  logic  lost;
  logic  mac_start;
  logic  mac_done;
  logic  div_done;
  logic  out_free;

  logic signed [SB:0]   off_left;
  logic signed [SB:0]   off_mid;
  logic signed [SB:0]   off_right;
  logic signed [SB:0]   thresh_x;
  logic signed [EW-1:0] error;
  logic signed [EW-1:0] error_last;
  logic signed [RW-1:0] rate;
  logic signed [EW-1:0] err_r;
  logic signed [RW-1:0] rate_r;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] quo;
  logic [SIDE_BITS-1:0] indicator;
  logic [SIDE_BITS-1:0] indicator_next;
  logic                 halted;

  logic signed [AW:0] base_x;
  logic signed [AW:0] full_x;
  logic signed [AW:0] sum_left;
  logic signed [AW:0] sum_right;
  logic signed [AW:0] quo_x2;
  logic signed [AW:0] spill_right;
  logic signed [AW:0] spill_left;
  logic [7:0]         duty_left;
  logic [7:0]         duty_right;

  logic [7:0]           res_left;
  logic [7:0]           res_right;
  logic [SIDE_BITS-1:0] res_side;
  logic                 res_stop;

  assign s_left  = s_tdata[SB-1:0];
  assign s_mid   = s_tdata[2*SB-1:SB];
  assign s_right = s_tdata[3*SB-1:2*SB];
  assign kind    = kind_t'(s_tuser);

  assign accept   = s_tvalid && s_tready;
  assign run_beat = accept && (kind == KIND_RUN);
  assign out_free = !m_tvalid || m_tready;

  lfps_cal #(.SAMPLE_BITS(SAMPLE_BITS)) u_cal (
    .clk        (clk),
    .rst        (rst),
    .upd_low    (accept && (kind == KIND_CAL_LOW)),
    .upd_high   (accept && (kind == KIND_CAL_HIGH)),
    .s_left     (s_left),
    .s_mid      (s_mid),
    .s_right    (s_right),
    .low_left   (low_left),
    .low_mid    (low_mid),
    .low_right  (low_right),
    .high_left  (high_left),
    .high_mid   (high_mid),
    .high_right (high_right)
  );

  assign off_left  = $signed({1'b0, s_left}) - $signed({1'b0, low_left});
  assign off_mid   = $signed({1'b0, s_mid}) - $signed({1'b0, low_mid});
  assign off_right = $signed({1'b0, s_right}) - $signed({1'b0, low_right});
  assign thresh_x  = $signed({{(SB-7){1'b0}}, stop_thresh});
  assign lost      = (off_left < thresh_x) && (off_mid < thresh_x) && (off_right < thresh_x);

  assign error = $signed({2'b00, s_left}) - $signed({2'b00, high_left})
               + $signed({2'b00, high_right}) - $signed({2'b00, s_right});
  assign rate  = $signed({error[EW-1], error}) - $signed({error_last[EW-1], error_last});

  always_comb begin
    indicator_next = indicator;
    if (error > 0) indicator_next = SIDE_POS;
    else if (error < 0) indicator_next = SIDE_NEG;
  end

  lfps_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .p_num (p_num),
    .d_num (d_num),
    .err   (err_r),
    .rate  (rate_r),
    .done  (mac_done),
    .acc   (acc)
  );

  lfps_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (mac_done),
    .num   (acc),
    .den   (gain_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign base_x      = $signed({{(AW-7){1'b0}}, base_speed});
  assign full_x      = $signed({{(AW-7){1'b0}}, DUTY_MAX});
  assign sum_left    = base_x + $signed({quo[AW-1], quo});
  assign sum_right   = base_x - $signed({quo[AW-1], quo});
  assign quo_x2      = $signed({quo, 1'b0});
  assign spill_right = full_x - quo_x2;
  assign spill_left  = full_x + quo_x2;

  always_comb begin
    if (sum_left > full_x) begin
      duty_left  = DUTY_MAX;
      duty_right = spill_right[AW] ? 8'd0 : spill_right[7:0];
    end else if (sum_right > full_x) begin
      duty_left  = spill_left[AW] ? 8'd0 : spill_left[7:0];
      duty_right = DUTY_MAX;
    end else begin
      duty_left  = sum_left[AW] ? 8'd0 : sum_left[7:0];
      duty_right = sum_right[AW] ? 8'd0 : sum_right[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE);
    mac_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (run_beat) begin
          if (halted || lost) state_next = ST_OUT;
          else begin
            state_next = ST_MAC;
            mac_start  = 1'b1;
          end
        end
      end
      ST_MAC: if (mac_done) state_next = ST_DIV;
      ST_DIV: if (div_done) state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed  <= BASE_SPEED_RESET;
      stop_thresh <= STOP_THRESH_RESET;
      p_num       <= P_NUM_RESET;
      d_num       <= D_NUM_RESET;
      gain_den    <= GAIN_DEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SPEED:  base_speed  <= cfg_data;
        REG_STOP_THRESH: stop_thresh <= cfg_data;
        REG_P_NUM:       p_num       <= cfg_data;
        REG_D_NUM:       d_num       <= cfg_data;
        REG_GAIN_DEN:    gain_den    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_last <= '0;
      indicator  <= SIDE_NONE;
      halted     <= 1'b0;
    end else if (run_beat && !halted) begin
      error_last <= error;
      indicator  <= indicator_next;
      halted     <= lost;
    end
  end

  always_ff @(posedge clk) begin
    if (run_beat) begin
      err_r  <= error;
      rate_r <= rate;
      if (halted) begin
        res_left  <= 8'd0;
        res_right <= 8'd0;
        res_side  <= indicator;
        res_stop  <= 1'b1;
      end else begin
        res_left  <= 8'd0;
        res_right <= 8'd0;
        res_side  <= indicator_next;
        res_stop  <= lost;
      end
    end else if (div_done) begin
      res_left  <= duty_left;
      res_right <= duty_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if ((state == ST_OUT) && out_free) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      m_tdata <= {{OUT_PAD_BITS{1'b0}}, res_stop, res_side, res_right, res_left};
    end
  end

endmodule

// ----- hdl/lfps_cal.sv -----
// Per-sensor calibration minima and maxima.
module lfps_cal #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   upd_low,
  input  logic                   upd_high,
  input  logic [SAMPLE_BITS-1:0] s_left,
  input  logic [SAMPLE_BITS-1:0] s_mid,
  input  logic [SAMPLE_BITS-1:0] s_right,
  output logic [SAMPLE_BITS-1:0] low_left,
  output logic [SAMPLE_BITS-1:0] low_mid,
  output logic [SAMPLE_BITS-1:0] low_right,
  output logic [SAMPLE_BITS-1:0] high_left,
  output logic [SAMPLE_BITS-1:0] high_mid,
  output logic [SAMPLE_BITS-1:0] high_right
);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_left   <= '1;
      low_mid    <= '1;
      low_right  <= '1;
      high_left  <= '0;
      high_mid   <= '0;
      high_right <= '0;
    end else begin
      if (upd_low) begin
        if (s_left < low_left) low_left <= s_left;
        if (s_mid < low_mid) low_mid <= s_mid;
        if (s_right < low_right) low_right <= s_right;
      end
      if (upd_high) begin
        if (s_left > high_left) high_left <= s_left;
        if (s_mid > high_mid) high_mid <= s_mid;
        if (s_right > high_right) high_right <= s_right;
      end
    end
  end

endmodule

// ----- hdl/lfps_mac.sv -----
// Bit-serial weighted sum p*error + d*rate, one weight bit per cycle.
module lfps_mac #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [lfps_pkg::GAIN_BITS-1:0]          p_num,
  input  logic [lfps_pkg::GAIN_BITS-1:0]          d_num,
  input  logic signed [SAMPLE_BITS+1:0]           err,
  input  logic signed [SAMPLE_BITS+2:0]           rate,
  output logic                                    done,
  output logic signed [SAMPLE_BITS+11:0]          acc
);

  import lfps_pkg::*;

  localparam int EW = SAMPLE_BITS + 2;
  localparam int RW = SAMPLE_BITS + 3;
  localparam int AW = SAMPLE_BITS + 12;
  localparam int CW = $clog2(GAIN_BITS);

  logic [GAIN_BITS-1:0] p_sh;
  logic [GAIN_BITS-1:0] d_sh;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 last;
  logic [AW-1:0]        term_p;
  logic [AW-1:0]        term_d;

  assign last   = (cnt == CW'(GAIN_BITS - 1));
  assign term_p = p_sh[GAIN_BITS-1] ? {{(AW-EW){err[EW-1]}}, err} : '0;
  assign term_d = d_sh[GAIN_BITS-1] ? {{(AW-RW){rate[RW-1]}}, rate} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      p_sh <= p_num;
      d_sh <= d_num;
    end else if (busy) begin
      acc  <= $signed({acc[AW-2:0], 1'b0} + term_p + term_d);
      p_sh <= {p_sh[GAIN_BITS-2:0], 1'b0};
      d_sh <= {d_sh[GAIN_BITS-2:0], 1'b0};
    end
  end

endmodule

// ----- hdl/lfps_div.sv -----
// Bit-serial restoring divider, truncating toward zero.
module lfps_div #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [SAMPLE_BITS+11:0]  num,
  input  logic [lfps_pkg::GAIN_BITS-1:0]  den,
  output logic                            done,
  output logic signed [SAMPLE_BITS+11:0]  quo
);

  import lfps_pkg::*;

  localparam int AW = SAMPLE_BITS + 12;
  localparam int CW = $clog2(AW);

  logic [AW-1:0]        mag;
  logic [GAIN_BITS-1:0] rem;
  logic [GAIN_BITS-1:0] den_r;
  logic                 neg;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 last;
  logic [GAIN_BITS:0]   trial;
  logic                 fits;

  assign last  = (cnt == CW'(AW - 1));
  assign trial = {rem, mag[AW-1]};
  assign fits  = (trial >= {1'b0, den_r});
  assign quo   = neg ? $signed(-mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[AW-1];
      mag   <= num[AW-1] ? -num : num;
      rem   <= '0;
      den_r <= (den == '0) ? GAIN_BITS'(1) : den;
    end else if (busy) begin
      rem <= fits ? GAIN_BITS'(trial - {1'b0, den_r}) : trial[GAIN_BITS-1:0];
      mag <= {mag[AW-2:0], fits};
    end
  end

endmodule

// ----- hdl/lfps_checker.sv -----
// Port-level assertions for the line follower steering block, with bind.
`include "line_follow_pd_steering_macros.svh"

module lfps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [lfps_pkg::KIND_BITS-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lfps_pkg::OUT_BITS-1:0]  m_tdata
);

  import lfps_pkg::*;

  `LFPS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")
  `LFPS_ASSERT_IMP(a_stop_zero, m_tvalid && m_tdata[OUT_USED_BITS-1], m_tdata[2*DUTY_BITS-1:0] == '0, "stopped beat with nonzero duty")
  `LFPS_ASSERT_NXT(a_run_busy, s_tvalid && s_tready && (s_tuser == KIND_RUN), !s_tready, "run beat did not hold off input")
  `LFPS_ASSERT_NXT_ANY(a_rst_clear, rst, !m_tvalid, "output valid after reset")

endmodule

bind line_follow_pd_steering lfps_checker u_lfps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
